[rtl/ctqc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// CAN transmit queue coalescer package
// Shared widths, constants, status codes and sequencer state type.
// ----------------------------------------------------------------------------
package ctqc_pkg;
	localparam int DEPTH  = 128;
	localparam int AW     = $clog2(DEPTH);
	localparam int OCC_W  = AW + 1;
	localparam int HDR_W  = 15;

	localparam logic [10:0] ID_MAX     = 11'h7FF;
	localparam logic [3:0]  DLC_MAX    = 4'd8;
	localparam logic [7:0]  SPEED_CODE = 8'hA2;
	localparam logic [7:0]  STOP_CODE  = 8'h81;

	localparam logic [7:0]  DROP_RST  = 8'd100;
	localparam logic [10:0] FIRST_RST = 11'h141;
	localparam logic [10:0] LAST_RST  = 11'h160;

	localparam logic [1:0] REG_DROP  = 2'd0;
	localparam logic [1:0] REG_FIRST = 2'd1;
	localparam logic [1:0] REG_LAST  = 2'd2;

	localparam logic [1:0] ST_QUEUED    = 2'd0;
	localparam logic [1:0] ST_REJECTED  = 2'd1;
	localparam logic [1:0] ST_DELIVERED = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP_RD,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_INSERT,
		S_DONE
	} seq_state_t;

	// store access request from the sequencer
	typedef struct packed {
		logic             we;
		logic [AW-1:0]    waddr;
		logic [HDR_W-1:0] whdr;
		logic [63:0]      wpay;
		logic [AW-1:0]    raddr;
	} mem_req_t;

	function automatic logic is_drive(input logic [3:0] d, input logic [7:0] b0);
		return (d != 4'd0) && ((b0 == SPEED_CODE) || (b0 == STOP_CODE));
	endfunction
endpackage
`default_nettype wire

[rtl/ctqc_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// CAN transmit queue frame store
// One write port and one registered read port over header and payload.
// ----------------------------------------------------------------------------
module ctqc_store (
	input  wire logic                            clk,
	input  wire ctqc_pkg::mem_req_t              req,
	output logic [ctqc_pkg::HDR_W-1:0]           rhdr,
	output logic [63:0]                          rpay
);
	import ctqc_pkg::*;

	logic [HDR_W+63:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= {req.whdr, req.wpay};
		end
		{rhdr, rpay} <= mem_q[req.raddr];
	end
endmodule
`default_nettype wire

[rtl/can_tx_queue_coalescer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// CAN transmit queue coalescer
// Circular frame queue with coalescing of motor drive frames.
// ----------------------------------------------------------------------------
// Pulse start with cmd, can_id, dlc and payload while busy is low. A pop
// reads the head entry, a rejected push goes straight to the result, and an
// ordinary push inserts after one scan read; a drive push walks every queued
// entry through the single store read port, dropping matching drive frames,
// before it inserts.
// One result transaction appears on the result ports with done high for
// exactly one cycle; status, the popped frame, depth and the four wrapping
// counters are presented together. The receiver cannot stall, so results are
// never held. The configuration port (cfg_we, cfg_index, cfg_data) writes a
// register at once and is to be used only while busy is low.
// Reset clears pointers, occupancy, counters and restores configuration
// defaults; the store contents are left as they are since only queued
// entries are ever read.
// ----------------------------------------------------------------------------
module can_tx_queue_coalescer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cmd,
	input  wire logic [28:0] can_id,
	input  wire logic [3:0]  dlc,
	input  wire logic [63:0] payload,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [10:0] cfg_data,
	output logic             done,
	output logic [1:0]       status,
	output logic [10:0]      out_id,
	output logic [3:0]       out_dlc,
	output logic [63:0]      out_payload,
	output logic [7:0]       fill_level,
	output logic [31:0]      queued_total,
	output logic [31:0]      coalesced_total,
	output logic [31:0]      dropped_total,
	output logic [31:0]      stop_total
);
	import ctqc_pkg::*;

	seq_state_t state_q, state_d;
	logic [7:0]  drop_q;
	logic [10:0] first_q, last_q;
	logic [AW-1:0] head_q;
	logic [OCC_W-1:0] occ_q, kept_q, k_q;
	logic [31:0] acc_q, merg_q, evic_q, halt_q;
	logic [10:0] id_q;
	logic [3:0]  dlc_q;
	logic [63:0] pay_q;
	logic        pop_q;
	logic [1:0]  status_q;
	logic [10:0] oid_q;
	logic [3:0]  odlc_q;
	logic [63:0] opay_q;
	logic        done_q;

	mem_req_t req;
	logic [HDR_W-1:0] rhdr;
	logic [63:0]      rpay;

	ctqc_store u_store (.clk(clk), .req(req), .rhdr(rhdr), .rpay(rpay));

	logic accept;
	logic rej, in_win, drv, stop_in, match, scan_end;
	logic [AW-1:0] src_a, dst_a, tail_a, occ_a;

	assign accept   = start && (state_q == S_IDLE);
	assign rej      = (can_id[28:11] != '0) || (dlc > DLC_MAX);
	assign in_win   = (id_q >= first_q) && (id_q <= last_q);
	assign drv      = in_win && is_drive(dlc_q, pay_q[7:0]);
	assign stop_in  = pay_q[7:0] == STOP_CODE;
	assign src_a    = head_q + k_q[AW-1:0];
	assign dst_a    = head_q + kept_q[AW-1:0];
	assign occ_a    = occ_q[AW-1:0];
	assign tail_a   = head_q + occ_a;
	assign match    = (rhdr[10:0] == id_q) && is_drive(rhdr[14:11], rpay[7:0]);
	assign scan_end = (k_q == occ_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd == CMD_POP) state_d = S_POP_RD;
					else if (rej)       state_d = S_DONE;
					else                state_d = S_SCAN_RD;
				end
			end
			S_POP_RD:   state_d = S_DONE;
			S_SCAN_RD:  state_d = (!drv || scan_end) ? S_INSERT : S_SCAN_CHK;
			S_SCAN_CHK: state_d = S_SCAN_RD;
			S_INSERT:   state_d = S_DONE;
			S_DONE:     state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req       = '0;
		req.raddr = (state_q == S_POP_RD) ? head_q : src_a;
		req.whdr  = {dlc_q, id_q};
		req.wpay  = pay_q;
		case (state_q)
			S_SCAN_CHK: begin
				req.we    = !match;
				req.waddr = dst_a;
				req.whdr  = rhdr;
				req.wpay  = rpay;
			end
			S_INSERT: begin
				req.we = 1'b1;
				// a stop frame goes in front of the head, or over the head entry when the queue is full
				if (drv && stop_in)
					req.waddr = head_q - ((occ_q == OCC_W'(DEPTH)) ? AW'(0) : AW'(1));
				else
					req.waddr = tail_a;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			drop_q  <= DROP_RST;
			first_q <= FIRST_RST;
			last_q  <= LAST_RST;
			head_q  <= '0;
			occ_q   <= '0;
			kept_q  <= '0;
			k_q     <= '0;
			acc_q   <= '0;
			merg_q  <= '0;
			evic_q  <= '0;
			halt_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_DONE);
			if (cfg_we) begin
				case (cfg_index)
					REG_DROP:  drop_q  <= cfg_data[7:0];
					REG_FIRST: first_q <= cfg_data;
					REG_LAST:  last_q  <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					k_q    <= '0;
					kept_q <= '0;
				end
				S_POP_RD: begin
					if (occ_q != '0) begin
						head_q <= head_q + AW'(1);
						occ_q  <= occ_q - OCC_W'(1);
					end
				end
				S_SCAN_RD: begin
					if (drv && scan_end) occ_q <= kept_q;
				end
				S_SCAN_CHK: begin
					k_q <= k_q + OCC_W'(1);
					if (match) merg_q <= merg_q + 32'd1;
					else       kept_q <= kept_q + OCC_W'(1);
				end
				S_INSERT: begin
					acc_q <= acc_q + 32'd1;
					if (drv) begin
						if (occ_q == OCC_W'(DEPTH)) begin
							evic_q <= evic_q + 32'd1;
							if (stop_in) begin
								halt_q <= halt_q + 32'd1;
							end else begin
								head_q <= head_q + AW'(1);
								occ_q  <= occ_q;
							end
						end else begin
							occ_q <= occ_q + OCC_W'(1);
							if (stop_in) begin
								head_q <= head_q - AW'(1);
								halt_q <= halt_q + 32'd1;
							end
						end
					end else if ((occ_q != '0) && ((occ_q >= OCC_W'(drop_q)) ||
						(occ_q == OCC_W'(DEPTH)))) begin
						evic_q <= evic_q + 32'd1;
						head_q <= head_q + AW'(1);
					end else begin
						occ_q <= occ_q + OCC_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q  <= can_id[10:0];
			dlc_q <= dlc;
			pay_q <= payload;
			pop_q <= cmd;
			status_q <= (cmd == CMD_POP) ? ST_EMPTY : (rej ? ST_REJECTED : ST_QUEUED);
			oid_q  <= '0;
			odlc_q <= '0;
			opay_q <= '0;
		end
		if (state_q == S_POP_RD && occ_q != '0) begin
			status_q <= ST_DELIVERED;
		end
		if (state_q == S_DONE && pop_q && status_q == ST_DELIVERED) begin
			oid_q  <= rhdr[10:0];
			odlc_q <= rhdr[14:11];
			opay_q <= rpay;
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign status          = status_q;
	assign out_id          = oid_q;
	assign out_dlc         = odlc_q;
	assign out_payload     = opay_q;
	assign fill_level      = 8'(occ_q);
	assign queued_total    = acc_q;
	assign coalesced_total = merg_q;
	assign dropped_total   = evic_q;
	assign stop_total      = halt_q;
endmodule
`default_nettype wire
